// ===== rtl/psrl_pkg.sv =====
// Package for the per-source rate limiter: word types, token and finish
// structs, configuration register codes and the window-end saturation helper.
// No dependencies.
package psrl_pkg;

    localparam int TIME_W   = 48;
    localparam int ADDR_W   = 32;
    localparam int COUNT_W  = 17;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
    localparam logic [CFG_W-1:0]   PERIOD_RESET = 16'd1000;
    localparam logic [CFG_W-1:0]   LIMIT_RESET  = 16'd0;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MS  = 8'd1;

    typedef struct packed {
        logic [ADDR_W-1:0] source_addr;
        logic [TIME_W-1:0] now_ms;
    } t_in_word;

    typedef struct packed {
        logic allowed;
        logic table_full;
    } t_out_word;

    // Search token that walks down the row of slot cells.
    typedef struct packed {
        logic valid;
        logic match_seen;
        logic free_seen;
        logic allowed;
    } t_tok;

    // Broadcast that closes a search: claim tells the reserved cell to store.
    typedef struct packed {
        logic valid;
        logic claim;
    } t_fin;

    // Saturate a 49-bit sum to the 48-bit time range.
    function automatic logic [TIME_W-1:0] sat_time(input logic [TIME_W:0] v);
        logic [TIME_W-1:0] r;
        r = v[TIME_W] ? {TIME_W{1'b1}} : v[TIME_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/psrl_cell.sv =====
// One slot of the source table: holds a source, its window end and count.
// Depends on psrl_pkg.
module psrl_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  psrl_pkg::t_in_word              i_req,
    input  logic [psrl_pkg::CFG_W-1:0]      i_period,
    input  logic [psrl_pkg::CFG_W-1:0]      i_limit,
    input  psrl_pkg::t_tok                  i_tok,
    input  psrl_pkg::t_fin                  i_fin,
    output psrl_pkg::t_tok                  o_tok
);

    logic                              r_used, n_used;
    logic                              r_cand, n_cand;
    logic [psrl_pkg::ADDR_W-1:0]       r_source, n_source;
    logic [psrl_pkg::TIME_W-1:0]       r_end, n_end;
    logic [psrl_pkg::COUNT_W-1:0]      r_count, n_count;
    psrl_pkg::t_tok                    r_tok, n_tok;

    logic [psrl_pkg::TIME_W:0]         w_end_plus;
    logic [psrl_pkg::TIME_W:0]         w_now_plus;
    logic [psrl_pkg::COUNT_W-1:0]      w_count_inc;
    logic                              w_live;
    logic                              w_hit;

    assign w_end_plus = {1'b0, r_end} + (psrl_pkg::TIME_W+1)'(i_period);
    assign w_now_plus = {1'b0, i_req.now_ms} + (psrl_pkg::TIME_W+1)'(i_period);
    assign w_live = r_used && ({1'b0, i_req.now_ms} < w_end_plus);
    assign w_hit  = w_live && (r_source == i_req.source_addr);
    assign w_count_inc = (r_count == psrl_pkg::COUNT_MAX) ? r_count
                                                          : r_count + 1'b1;

    always_comb begin
        n_used   = r_used;
        n_cand   = r_cand;
        n_source = r_source;
        n_end    = r_end;
        n_count  = r_count;
        n_tok    = i_tok;
        if (i_tok.valid) begin
            if (w_hit && !i_tok.match_seen) begin
                n_tok.match_seen = 1'b1;
                if (i_req.now_ms > r_end) begin
                    n_end   = psrl_pkg::sat_time(w_end_plus);
                    n_count = psrl_pkg::COUNT_W'(1);
                end else begin
                    n_count       = w_count_inc;
                    n_tok.allowed = (w_count_inc <= psrl_pkg::COUNT_W'(i_limit));
                end
            end else if (!w_live && !i_tok.free_seen) begin
                // First free or stale slot is reserved until the search ends.
                n_tok.free_seen = 1'b1;
                n_cand          = 1'b1;
            end
        end
        if (i_fin.valid) begin
            if (i_fin.claim && r_cand) begin
                n_used   = 1'b1;
                n_source = i_req.source_addr;
                n_end    = psrl_pkg::sat_time(w_now_plus);
                n_count  = psrl_pkg::COUNT_W'(1);
            end
            n_cand = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= 1'b0;
            r_cand    <= 1'b0;
            r_tok     <= '0;
        end else begin
            r_used    <= n_used;
            r_cand    <= n_cand;
            r_tok     <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_source <= n_source;
        r_end    <= n_end;
        r_count  <= n_count;
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/per_source_rate_limiter.sv =====
// Top level of the per-source fixed-window rate limiter.
// Depends on psrl_pkg and psrl_cell.
//
// This block decides, for each request word (IPv4 source and millisecond
// timestamp), whether the source is within its rate and reports one result
// word per request. The source table is a row of TABLE_SLOTS identical cells,
// one per slot. A search token enters the first cell after a request is
// accepted and moves one cell per cycle; each cell compares its own entry
// against the broadcast request as the token passes. The result word is
// presented through the pending and output registers once the token leaves
// the last cell, and the next request can be accepted once that result has
// left the pending register; the length of the cell row sets this. When the
// rate limit is zero the table is skipped: the result word goes straight to
// the pending register and on to the output register. One request is in the
// table at a time; a new request is taken as soon as the previous one has
// produced its result, even if that result is still waiting at the output.
// Nothing is accepted on either input channel while reset is held.
// Configuration writes are otherwise always accepted and must only be
// issued while no request is in flight.
module per_source_rate_limiter #(
    parameter int TABLE_SLOTS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  psrl_pkg::t_in_word                 i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output psrl_pkg::t_out_word                o_out_word,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [psrl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [psrl_pkg::CFG_W-1:0]         i_cfg_data
);

    logic [psrl_pkg::CFG_W-1:0] r_limit, n_limit;
    logic [psrl_pkg::CFG_W-1:0] r_period, n_period;

    psrl_pkg::t_in_word   r_req, n_req;
    logic                 r_start, n_start;
    logic                 r_run, n_run;
    psrl_pkg::t_fin       r_fin, n_fin;
    logic                 r_pend_valid, n_pend_valid;
    psrl_pkg::t_out_word  r_pend_word, n_pend_word;
    logic                 r_out_valid, n_out_valid;
    psrl_pkg::t_out_word  r_out_word, n_out_word;

    psrl_pkg::t_tok       w_tok [0:TABLE_SLOTS];
    psrl_pkg::t_tok       w_tail;
    logic                 w_busy;
    logic                 w_in_fire;
    logic                 w_limit_off;

    // Token injected at the head of the row: nothing seen yet, allowed by default.
    assign w_tok[0] = '{valid: r_start, match_seen: 1'b0, free_seen: 1'b0,
                        allowed: 1'b1};

    genvar g;
    generate
        for (g = 0; g < TABLE_SLOTS; g++) begin : g_slot
            psrl_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_req    (r_req),
                .i_period (r_period),
                .i_limit  (r_limit),
                .i_tok    (w_tok[g]),
                .i_fin    (r_fin),
                .o_tok    (w_tok[g+1])
            );
        end
    endgenerate

    assign w_tail      = w_tok[TABLE_SLOTS];
    assign w_limit_off = (r_limit == '0);

    // Busy from acceptance until the result has left the pending register
    // and any slot claim has been written.
    assign w_busy      = r_run | r_fin.valid | r_pend_valid;
    assign o_in_ready  = i_rst_n && !w_busy;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign o_cfg_ready = i_rst_n;

    // Configuration registers.
    always_comb begin
        n_limit  = r_limit;
        n_period = r_period;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                psrl_pkg::CFG_RATE_LIMIT: n_limit  = i_cfg_data;
                psrl_pkg::CFG_PERIOD_MS:  n_period = i_cfg_data;
                default: ;
            endcase
        end
    end

    // Request sequencing and result delivery.
    always_comb begin
        n_req        = r_req;
        n_start      = 1'b0;
        n_run        = r_run;
        n_fin        = '{valid: 1'b0, claim: 1'b0};
        n_pend_valid = r_pend_valid;
        n_pend_word  = r_pend_word;
        n_out_valid  = r_out_valid;
        n_out_word   = r_out_word;

        if (w_in_fire) begin
            n_req = i_in_word;
            if (w_limit_off) begin
                // Limiting disabled: allow and leave the table alone.
                n_pend_valid = 1'b1;
                n_pend_word  = '{allowed: 1'b1, table_full: 1'b0};
            end else begin
                n_start = 1'b1;
                n_run   = 1'b1;
            end
        end

        if (w_tail.valid) begin
            n_run = 1'b0;
            // A new entry is stored only when no live entry matched.
            n_fin = '{valid: 1'b1,
                      claim: !w_tail.match_seen && w_tail.free_seen};
            n_pend_valid = 1'b1;
            n_pend_word.allowed    = w_tail.match_seen ? w_tail.allowed : 1'b1;
            n_pend_word.table_full = !w_tail.match_seen && !w_tail.free_seen;
        end

        if (r_pend_valid && (!r_out_valid || i_out_ready)) begin
            n_out_valid  = 1'b1;
            n_out_word   = r_pend_word;
            n_pend_valid = 1'b0;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit      <= psrl_pkg::LIMIT_RESET;
            r_period     <= psrl_pkg::PERIOD_RESET;
            r_start      <= 1'b0;
            r_run        <= 1'b0;
            r_fin        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_limit      <= n_limit;
            r_period     <= n_period;
            r_start      <= n_start;
            r_run        <= n_run;
            r_fin        <= n_fin;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_pend_word <= n_pend_word;
        r_out_word  <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for per_source_rate_limiter: a directed table, then random phases.
// Every result word is checked against a predictor of the source table kept in this file, or a typed-in verdict.
// Depends on psrl_pkg and the per_source_rate_limiter RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 64;
    // One request walks the whole cell row before its result word appears.
    localparam int LAT = SLOTS + 3;
    // Time budget for roughly 890 requests, with a wide margin.
    localparam int RUN_LIMIT_NS = 2_000_000;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;
    typedef enum {MIX_BURST, MIX_FLOOD, MIX_NOISE, MIX_OPEN} t_mix_kind;

    // Rows of the directed table. A request row either carries a typed-in verdict
    // (pin set) or is checked against the predictor.
    typedef struct packed {
        t_row_kind                      kind;
        logic [psrl_pkg::CFG_IDX_W-1:0] idx;
        logic [psrl_pkg::CFG_W-1:0]     data;
        logic [psrl_pkg::ADDR_W-1:0]    src;
        logic [psrl_pkg::TIME_W-1:0]    at_ms;
        logic                           pin;
        logic                           pin_allowed;
        logic                           pin_full;
    } t_step_row;

    localparam logic [psrl_pkg::TIME_W-1:0] T_MAX = {psrl_pkg::TIME_W{1'b1}};
    localparam logic [psrl_pkg::ADDR_W-1:0] SRC_A = 32'h0A00_0001;
    localparam logic [psrl_pkg::ADDR_W-1:0] SRC_C = 32'hC0A8_0101;
    localparam logic [psrl_pkg::ADDR_W-1:0] SRC_F = 32'hAA55_AA55;

    localparam t_step_row DIR_ROWS [25] = '{
        // Limit zero after reset: everything passes, extremes of both fields.
        '{ROW_REQ, psrl_pkg::CFG_RATE_LIMIT, 16'd0, 32'h0000_0000, 48'd0, 1'b1, 1'b1, 1'b0},
        '{ROW_REQ, psrl_pkg::CFG_RATE_LIMIT, 16'd0, 32'hFFFF_FFFF, T_MAX, 1'b1, 1'b1, 1'b0},
        '{ROW_CFG, psrl_pkg::CFG_RATE_LIMIT, 16'd2, 32'd0, 48'd0, 1'b0, 1'b0, 1'b0},
        // Two requests fit the window, the third is denied.
        '{ROW_REQ, psrl_pkg::CFG_RATE_LIMIT, 16'd0, SRC_A, 48'd100, 1'b1, 1'b1, 1'b0},
        '{ROW_REQ, psrl_pkg::CFG_RATE_LIMIT, 16'd0, SRC_A, 48'd200, 1'b1, 1'b1, 1'b0},
        '{ROW_REQ, psrl_pkg::CFG_RATE_LIMIT, 16'd0, SRC_A, 48'd300, 1'b1, 1'b0, 1'b0},
        // Past the window end the window moves on; a whole period later the entry is stale.
        '{ROW_REQ, psrl_pkg::CFG_RATE_LIMIT, 16'd0, SRC_A, 48'd1101, 1'b0, 1'b0, 1'b0},
        '{ROW_REQ, psrl_pkg::CFG_RATE_LIMIT, 16'd0, SRC_A, 48'd3100, 1'b0, 1'b0, 1'b0},
        '{ROW_REQ, psrl_pkg::CFG_RATE_LIMIT, 16'd0, 32'hFFFF_FFFF, 48'd3100, 1'b0, 1'b0, 1'b0},
        // Longest period near the top of time: the stored window end saturates.
        '{ROW_CFG, psrl_pkg::CFG_PERIOD_MS, 16'hFFFF, 32'd0, 48'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_REQ, psrl_pkg::CFG_RATE_LIMIT, 16'd0, SRC_C, 48'hFFFF_FFFF_FF00, 1'b1, 1'b1, 1'b0},
        '{ROW_REQ, psrl_pkg::CFG_RATE_LIMIT, 16'd0, SRC_C, 48'hFFFF_FFFF_FF00, 1'b0, 1'b0, 1'b0},
        '{ROW_REQ, psrl_pkg::CFG_RATE_LIMIT, 16'd0, SRC_C, T_MAX, 1'b1, 1'b0, 1'b0},
        // Time going backwards.
        '{ROW_REQ, psrl_pkg::CFG_RATE_LIMIT, 16'd0, SRC_A, 48'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG, psrl_pkg::CFG_RATE_LIMIT, 16'hFFFF, 32'd0, 48'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_REQ, psrl_pkg::CFG_RATE_LIMIT, 16'd0, 32'h7F00_0001, 48'd50, 1'b1, 1'b1, 1'b0},
        // Period zero: every request restarts the window and passes.
        '{ROW_CFG, psrl_pkg::CFG_RATE_LIMIT, 16'd1, 32'd0, 48'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_CFG, psrl_pkg::CFG_PERIOD_MS, 16'd0, 32'd0, 48'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_REQ, psrl_pkg::CFG_RATE_LIMIT, 16'd0, 32'h55AA_55AA, 48'd10, 1'b1, 1'b1, 1'b0},
        '{ROW_REQ, psrl_pkg::CFG_RATE_LIMIT, 16'd0, 32'h55AA_55AA, 48'd10, 1'b1, 1'b1, 1'b0},
        // Shortest nonzero period with limit one.
        '{ROW_CFG, psrl_pkg::CFG_PERIOD_MS, 16'd1, 32'd0, 48'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_REQ, psrl_pkg::CFG_RATE_LIMIT, 16'd0, SRC_F, 48'd20, 1'b0, 1'b0, 1'b0},
        '{ROW_REQ, psrl_pkg::CFG_RATE_LIMIT, 16'd0, SRC_F, 48'd20, 1'b1, 1'b0, 1'b0},
        '{ROW_REQ, psrl_pkg::CFG_RATE_LIMIT, 16'd0, SRC_F, 48'd21, 1'b0, 1'b0, 1'b0},
        '{ROW_REQ, psrl_pkg::CFG_RATE_LIMIT, 16'd0, SRC_F, 48'd22, 1'b0, 1'b0, 1'b0}
    };

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    psrl_pkg::t_in_word             i_in_word = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    psrl_pkg::t_out_word            o_out_word;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [psrl_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [psrl_pkg::CFG_W-1:0]     i_cfg_data = '0;

    // Typed-in verdict that travels with the request word on the input channel.
    logic                           word_pinned = 1'b0;
    psrl_pkg::t_out_word            pinned_word = '0;

    bit                             idle_on = 1'b1;
    int unsigned                    requests_sent = 0;
    int unsigned                    verdicts_seen = 0;
    int unsigned                    bad_verdicts = 0;
    psrl_pkg::t_out_word            verdict_q[$];

    // Predictor state: a copy of the source table and of both registers.
    logic [psrl_pkg::CFG_W-1:0]     lim_now = psrl_pkg::LIMIT_RESET;
    logic [psrl_pkg::CFG_W-1:0]     per_now = psrl_pkg::PERIOD_RESET;
    logic                           src_used [SLOTS] = '{default: 1'b0};
    logic [psrl_pkg::ADDR_W-1:0]    src_addr [SLOTS];
    logic [psrl_pkg::TIME_W-1:0]    win_end  [SLOTS];
    logic [psrl_pkg::COUNT_W-1:0]   win_hits [SLOTS];

    per_source_rate_limiter #(
        .TABLE_SLOTS(SLOTS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Decides one request and updates the table copy. An entry is live while now lies
    // below its window end plus one period; anything else is a slot free for the taking.
    function automatic psrl_pkg::t_out_word judge_request(input psrl_pkg::t_in_word w);
        int                          i;
        int                          hit;
        int                          spare;
        logic [psrl_pkg::TIME_W:0]   sum;
        psrl_pkg::t_out_word         r;
        hit = -1;
        spare = -1;
        r.allowed = 1'b1;
        r.table_full = 1'b0;
        if (lim_now != '0) begin
            for (i = 0; i < SLOTS; i++) begin
                if (src_used[i] && ({1'b0, w.now_ms} < {1'b0, win_end[i]} + per_now)) begin
                    if (hit < 0 && src_addr[i] == w.source_addr) begin
                        hit = i;
                    end
                end else if (spare < 0) begin
                    spare = i;
                end
            end
            if (hit >= 0) begin
                if (w.now_ms > win_end[hit]) begin
                    sum = {1'b0, win_end[hit]} + per_now;
                    win_end[hit] = sum[psrl_pkg::TIME_W] ? T_MAX
                                                         : sum[psrl_pkg::TIME_W-1:0];
                    win_hits[hit] = psrl_pkg::COUNT_W'(1);
                end else begin
                    if (win_hits[hit] != psrl_pkg::COUNT_MAX) begin
                        win_hits[hit] = win_hits[hit] + 1'b1;
                    end
                    if (win_hits[hit] > lim_now) begin
                        r.allowed = 1'b0;
                    end
                end
            end else if (spare >= 0) begin
                sum = {1'b0, w.now_ms} + per_now;
                src_used[spare] = 1'b1;
                src_addr[spare] = w.source_addr;
                win_end[spare] = sum[psrl_pkg::TIME_W] ? T_MAX : sum[psrl_pkg::TIME_W-1:0];
                win_hits[spare] = psrl_pkg::COUNT_W'(1);
            end else begin
                r.table_full = 1'b1;
            end
        end
        return r;
    endfunction

    // Watches all three channels. Values read here are those from just before the
    // edge, so the handshakes seen are exactly the ones the block sees.
    always @(posedge i_clk) begin : watch
        psrl_pkg::t_out_word want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    psrl_pkg::CFG_RATE_LIMIT: lim_now = i_cfg_data;
                    psrl_pkg::CFG_PERIOD_MS:  per_now = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                want = judge_request(i_in_word);
                verdict_q.push_back(word_pinned ? pinned_word : want);
            end
            if (o_out_valid && i_out_ready) begin
                verdicts_seen++;
                if (verdict_q.size() == 0) begin
                    bad_verdicts++;
                    if (bad_verdicts <= 10) begin
                        $display("unexpected result word %b with nothing outstanding",
                                 o_out_word);
                    end
                end else begin
                    want = verdict_q.pop_front();
                    if (o_out_word.allowed !== want.allowed
                            || o_out_word.table_full !== want.table_full) begin
                        bad_verdicts++;
                        if (bad_verdicts <= 10) begin
                            $display({"result %0d: allowed exp %b got %b, ",
                                      "table_full exp %b got %b"},
                                     verdicts_seen, want.allowed, o_out_word.allowed,
                                     want.table_full, o_out_word.table_full);
                        end
                    end
                end
            end
        end
    end

    // Result side: when idle_on is set, inserts a random stall before taking each word.
    initial begin : sink
        int unsigned stall;
        stall = 0;
        forever begin
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_rst_n));
            stall = idle_on ? $urandom_range(0, 4) : 0;
        end
    end

    task automatic offer_request(input psrl_pkg::t_in_word w, input logic pin,
                                 input psrl_pkg::t_out_word pin_res);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_in_word   <= w;
        word_pinned <= pin;
        pinned_word <= pin_res;
        do @(posedge i_clk); while (!o_in_ready);
        requests_sent++;
    endtask

    // Holds the input side until every result word is back, then lets the cell row drain.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (verdicts_seen != requests_sent) @(posedge i_clk);
        repeat (LAT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [psrl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [psrl_pkg::CFG_W-1:0] val);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Register value that favors the ends of the range.
    function automatic logic [psrl_pkg::CFG_W-1:0] cfg_value_draw();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 16'd1;
            2:       return '1;
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin : stimulus
        int                          ph;
        int                          k;
        int                          n_items;
        t_mix_kind                   mix;
        logic [psrl_pkg::CFG_W-1:0]  lim;
        logic [psrl_pkg::CFG_W-1:0]  per;
        logic [psrl_pkg::ADDR_W-1:0] src;
        logic [psrl_pkg::ADDR_W-1:0] pool [8];
        logic [psrl_pkg::ADDR_W-1:0] seen [$];
        logic [psrl_pkg::TIME_W-1:0] now_base;
        logic [psrl_pkg::TIME_W-1:0] stamp;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_ROWS[r]) begin
            if (DIR_ROWS[r].kind == ROW_CFG) begin
                write_reg(DIR_ROWS[r].idx, DIR_ROWS[r].data);
            end else begin
                offer_request({DIR_ROWS[r].src, DIR_ROWS[r].at_ms}, DIR_ROWS[r].pin,
                              {DIR_ROWS[r].pin_allowed, DIR_ROWS[r].pin_full});
            end
        end

        // Random phases, each under its own register setting. Bursts hammer a few
        // sources against a small limit; floods overrun the table with new sources;
        // noise throws arbitrary times and settings; open phases run with limit zero.
        now_base = 48'd5000;
        for (ph = 0; ph < 12; ph++) begin
            mix = t_mix_kind'(ph % 4);
            idle_on = ($urandom_range(0, 3) != 0);
            foreach (pool[j]) pool[j] = $urandom();
            seen.delete();
            case (mix)
                MIX_BURST: begin
                    lim = 16'($urandom_range(1, 6));
                    per = 16'($urandom_range(1, 300));
                    n_items = 100;
                    // Jump far enough that entries of the last flood go stale.
                    now_base += 48'($urandom_range(140000, 200000));
                end
                MIX_FLOOD: begin
                    lim = 16'($urandom_range(1, 3));
                    per = '1;
                    n_items = 100;
                end
                MIX_NOISE: begin
                    lim = cfg_value_draw();
                    per = cfg_value_draw();
                    n_items = 60;
                end
                default: begin
                    lim = '0;
                    per = 16'($urandom());
                    n_items = 30;
                end
            endcase
            write_reg(psrl_pkg::CFG_RATE_LIMIT, lim);
            write_reg(psrl_pkg::CFG_PERIOD_MS, per);

            for (k = 0; k < n_items; k++) begin
                case (mix)
                    MIX_BURST: begin
                        case ($urandom_range(0, 19))
                            0:       src = $urandom();
                            1:       src = pool[$urandom_range(0, 2)]
                                           ^ (32'd1 << $urandom_range(0, 31));
                            default: src = pool[$urandom_range(0, 2)];
                        endcase
                        case ($urandom_range(0, 19))
                            0:          now_base += 48'(2 * per + $urandom_range(0, per));
                            1, 2, 3, 4: now_base += 48'($urandom_range(0, per));
                            default:    now_base += 48'($urandom_range(0, per / 16));
                        endcase
                        stamp = now_base;
                    end
                    MIX_FLOOD: begin
                        if (seen.size() != 0 && $urandom_range(0, 3) == 0) begin
                            src = seen[$urandom_range(0, seen.size() - 1)];
                        end else begin
                            src = $urandom();
                            seen.push_back(src);
                        end
                        now_base += 48'($urandom_range(0, 1));
                        stamp = now_base;
                    end
                    MIX_NOISE: begin
                        src = $urandom_range(0, 1) ? pool[$urandom_range(0, 7)] : $urandom();
                        stamp = $urandom_range(0, 1) ? {16'($urandom()), 32'($urandom())}
                                                     : now_base
                                                       + 48'($urandom_range(0, 2000));
                    end
                    default: begin
                        src = $urandom();
                        now_base += 48'($urandom_range(0, 50));
                        stamp = now_base;
                    end
                endcase
                offer_request({src, stamp}, 1'b0, '0);
            end
        end

        settle();
        if (bad_verdicts == 0 && verdict_q.size() == 0) begin
            $display("per_source_rate_limiter regression: pass");
        end else begin
            $display("per_source_rate_limiter regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("per_source_rate_limiter regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/psrl_pkg.sv
rtl/psrl_cell.sv
rtl/per_source_rate_limiter.sv
tb/tb.sv
